>>> design/sniffed_address_learning_table_defines.svh
// Assertion macros for the address learning table.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef SNIFFED_ADDRESS_LEARNING_TABLE_DEFINES_SVH
`define SNIFFED_ADDRESS_LEARNING_TABLE_DEFINES_SVH
`ifndef SYNTH
`define SALT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("address learning table assertion failed");
`define SALT_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("address learning table assertion failed");
`else
`define SALT_ASSERT(name, prop)
`define SALT_ASSERT_RST(name, prop)
`endif
`endif

>>> design/salt_pkg.sv
package salt_pkg;

  localparam int unsigned MaxEntriesDef  = 10;
  localparam int unsigned MaxChannelsDef = 6;

  // First address byte in the upper eight bits.
  localparam logic [15:0] MagicIdReset = 16'h3932;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ChanW   = 7;
  localparam int unsigned AddrW   = 40;
  localparam int unsigned EntryW  = 4;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned TotalW  = 4;
  localparam int unsigned ChTotW  = 3;
  localparam int unsigned MagicW  = 16;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 64;

  localparam logic [OpW-1:0] OpDwell  = 2'd0;
  localparam logic [OpW-1:0] OpPacket = 2'd1;
  localparam logic [OpW-1:0] OpRead   = 2'd2;

  // Result item; the first field sits in the highest bits.
  typedef struct packed {
    logic [ChTotW-1:0] read_channel_total;
    logic [ChanW-1:0]  read_channel;
    logic [AddrW-1:0]  read_address;
    logic [TotalW-1:0] entry_total;
    logic              dropped_full;
    logic              channel_added;
    logic              is_new_entry;
    logic [EntryW-1:0] hit_index;
    logic              magic_match;
  } res_t;

endpackage

>>> design/sniffed_address_learning_table.sv
// Address learning table for a channel-scanning sniffer. Items are processed one at a time
// under a small sequencer around a single 40-bit compare and one read port on the address
// memory. A dwell start, an unused operation code, a packet that fails the signal or magic
// check and a read of an entry not in use go straight to the output stage, and a read of a
// held entry passes through a read state first. A captured packet with signal and matching
// magic ID is scanned against the held entries, which reads and compares one stored address
// per cycle and stops at the first hit. On a miss it creates an entry, or drops the packet
// when the table is full. The result is held in an output register, so the next item is
// accepted while it waits. The address and channel memories are not cleared: only entries
// and slots that were written are ever returned, and no clearing pass follows reset.
`include "sniffed_address_learning_table_defines.svh"

module sniffed_address_learning_table
  import salt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES  = MaxEntriesDef,
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // channel, packet_address, signal_present, read_entry, read_slot, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // operation
  input  logic [OpW-1:0]      s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // magic_match, hit_index, is_new_entry, channel_added, dropped_full, entry_total,
  // read_address, read_channel, read_channel_total, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [MagicW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CcW     = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned SlW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned ChDepth = MAX_ENTRIES * MAX_CHANNELS;
  localparam int unsigned ChAw    = (ChDepth > 1) ? $clog2(ChDepth) : 1;
  localparam int unsigned CmpW    = (CntW > EntryW) ? CntW : EntryW;
  localparam int unsigned SCmpW   = (CcW > SlotW) ? CcW : SlotW;
  localparam int unsigned PadW    = OutDataW - $bits(res_t);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_APPEND = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  function automatic logic [ChAw-1:0] ch_addr(logic [IdxW-1:0] e, logic [SlW-1:0] s);
    return ChAw'(e) * ChAw'(MAX_CHANNELS) + ChAw'(s);
  endfunction

  logic [ChanW-1:0]  in_chan;
  logic [AddrW-1:0]  in_addr;
  logic              in_sig;
  logic [EntryW-1:0] in_rentry;
  logic [SlotW-1:0]  in_rslot;
  logic              in_fire, out_fire;

  logic [2:0]        state_q, state_d;
  logic [MagicW-1:0] magic_q;
  logic [ChanW-1:0]  cur_chan_q, cur_chan_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [MAX_ENTRIES-1:0][CcW-1:0] cnt_q, cnt_d;
  logic [MAX_ENTRIES-1:0]          seen_q, seen_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]   ent_q, ent_d;
  logic [AddrW-1:0]  pkt_addr_q, pkt_addr_d;
  logic [SlotW-1:0]  rslot_q, rslot_d;
  res_t              wrk_q, wrk_d;
  res_t              out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic [AddrW-1:0]  addr_mem [MAX_ENTRIES];
  logic [ChanW-1:0]  chan_mem [ChDepth];
  logic [AddrW-1:0]  addr_rd_q;
  logic [ChanW-1:0]  chan_rd_q;
  logic [IdxW-1:0]   addr_ra;
  logic [ChAw-1:0]   chan_ra, chan_wa;
  logic              addr_we, chan_we;
  logic              rentry_ok;

  assign in_chan   = s_axis_tdata_i[6:0];
  assign in_addr   = s_axis_tdata_i[46:7];
  assign in_sig    = s_axis_tdata_i[47];
  assign in_rentry = s_axis_tdata_i[51:48];
  assign in_rslot  = s_axis_tdata_i[54:52];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_vld_q;
  assign out_fire        = out_vld_q && m_axis_tready_i;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_q};
  assign cfg_ready_o     = 1'b1;

  assign rentry_ok = CmpW'(in_rentry) < CmpW'(used_q);

  // A read item addresses both memories straight from the input; the scan walks idx_q.
  assign addr_ra = (state_q == ST_IDLE) ? in_rentry[IdxW-1:0] : idx_q[IdxW-1:0];
  assign chan_ra = ch_addr(in_rentry[IdxW-1:0], in_rslot[SlW-1:0]);
  assign chan_wa = ch_addr(ent_q, cnt_q[ent_q][SlW-1:0]);

  always_ff @(posedge clk_i) begin
    addr_rd_q <= addr_mem[addr_ra];
    chan_rd_q <= chan_mem[chan_ra];
    if (addr_we) begin
      addr_mem[used_q[IdxW-1:0]] <= pkt_addr_q;
    end
    if (chan_we) begin
      chan_mem[chan_wa] <= cur_chan_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_chan_d = cur_chan_q;
    used_d     = used_q;
    cnt_d      = cnt_q;
    seen_d     = seen_q;
    idx_d      = idx_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    ent_d      = ent_q;
    pkt_addr_d = pkt_addr_q;
    rslot_d    = rslot_q;
    wrk_d      = wrk_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_fire;
    addr_we    = 1'b0;
    chan_we    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          wrk_d      = '0;
          pkt_addr_d = in_addr;
          rslot_d    = in_rslot;
          ent_d      = in_rentry[IdxW-1:0];
          idx_d      = '0;
          cmp_vld_d  = 1'b0;
          state_d    = ST_EMIT;
          unique case (s_axis_tuser_i)
            OpDwell: begin
              cur_chan_d = in_chan;
              seen_d     = '0;
            end
            OpPacket: begin
              if (in_sig && (in_addr[39:24] == magic_q)) begin
                wrk_d.magic_match = 1'b1;
                state_d           = ST_SCAN;
              end
            end
            OpRead: begin
              if (rentry_ok) begin
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // Reads run one entry ahead of the compare.
        if (cmp_vld_q && (addr_rd_q == pkt_addr_q)) begin
          ent_d           = cmp_idx_q;
          wrk_d.hit_index = EntryW'(cmp_idx_q);
          state_d         = ST_APPEND;
        end else if (idx_q < used_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[IdxW-1:0];
          idx_d     = idx_q + 1'b1;
        end else if (cmp_vld_q) begin
          cmp_vld_d = 1'b0;
        end else if (used_q < CntW'(MAX_ENTRIES)) begin
          addr_we                     = 1'b1;
          ent_d                       = used_q[IdxW-1:0];
          cnt_d[used_q[IdxW-1:0]]     = '0;
          seen_d[used_q[IdxW-1:0]]    = 1'b0;
          used_d                      = used_q + 1'b1;
          wrk_d.hit_index             = EntryW'(used_q);
          wrk_d.is_new_entry          = 1'b1;
          state_d                     = ST_APPEND;
        end else begin
          wrk_d.dropped_full = 1'b1;
          state_d            = ST_EMIT;
        end
      end

      ST_APPEND: begin
        if ((cnt_q[ent_q] < CcW'(MAX_CHANNELS)) && !seen_q[ent_q]) begin
          chan_we             = 1'b1;
          cnt_d[ent_q]        = cnt_q[ent_q] + 1'b1;
          seen_d[ent_q]       = 1'b1;
          wrk_d.channel_added = 1'b1;
        end
        state_d = ST_EMIT;
      end

      ST_READ: begin
        wrk_d.read_address       = addr_rd_q;
        wrk_d.read_channel_total = ChTotW'(cnt_q[ent_q]);
        if (SCmpW'(rslot_q) < SCmpW'(cnt_q[ent_q])) begin
          wrk_d.read_channel = chan_rd_q;
        end
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_d             = wrk_q;
          out_d.entry_total = TotalW'(used_q);
          out_vld_d         = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      magic_q    <= MagicIdReset;
      cur_chan_q <= '0;
      used_q     <= '0;
      cnt_q      <= '0;
      seen_q     <= '0;
      idx_q      <= '0;
      cmp_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_chan_q <= cur_chan_d;
      used_q     <= used_d;
      cnt_q      <= cnt_d;
      seen_q     <= seen_d;
      idx_q      <= idx_d;
      cmp_vld_q  <= cmp_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        magic_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    ent_q      <= ent_d;
    pkt_addr_q <= pkt_addr_d;
    rslot_q    <= rslot_d;
    wrk_q      <= wrk_d;
    out_q      <= out_d;
  end

  `SALT_ASSERT(busy_after_accept_a, in_fire |=> !s_axis_tready_o)
  `SALT_ASSERT(scan_in_range_a, (state_q == ST_SCAN) |-> (idx_q <= used_q))
  `SALT_ASSERT(used_in_range_a, used_q <= CntW'(MAX_ENTRIES))
  `SALT_ASSERT(new_entry_appends_a, (out_vld_q && out_q.is_new_entry) |-> out_q.channel_added)
  `SALT_ASSERT(drop_only_when_full_a, (out_vld_q && out_q.dropped_full) |-> (used_q == CntW'(MAX_ENTRIES)))
  `SALT_ASSERT_RST(no_result_in_reset_a, !rst_ni |=> !m_axis_tvalid_o)

endmodule
